// ===== hdl/pdtq_pkg.sv =====
// Shared types and constants of the periodic deadline timer queue.
`default_nettype none

package pdtq_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int MAX_RESULTS    = 16;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_SCHEDULED = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_COMPLETED = 3'd4
  } slot_st_e;

  typedef enum logic [3:0] {
    RES_EXPIRED     = 4'd0,
    RES_STARTED     = 4'd1,
    RES_START_IGN   = 4'd2,
    RES_CANCELLED   = 4'd3,
    RES_CANCEL_IGN  = 4'd4,
    RES_COMPLETED   = 4'd5,
    RES_RESCHEDULED = 4'd6,
    RES_CANCEL_ACK  = 4'd7,
    RES_NO_EXPIRY   = 4'd8
  } res_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TICK     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_PASS_END = 7'b0001000,
    S_FINAL    = 7'b0010000,
    S_CMD      = 7'b0100000,
    S_DONE_UPD = 7'b1000000
  } fsm_e;

endpackage

`default_nettype wire

// ===== hdl/pdtq_alu.sv =====
// Shared add/subtract unit for time arithmetic.
`default_nettype none

module pdtq_alu import pdtq_pkg::*; #(
  parameter int W = TIME_WIDTH_DEF
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] y_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pdtq_mem.sv =====
// Deadline and period storage, one write port and one registered read port.
`default_nettype none

module pdtq_mem import pdtq_pkg::*; #(
  parameter int DEPTH = NUM_SLOTS_DEF,
  parameter int TW    = TIME_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [TW-1:0]            wdl_i,
  input  logic [30:0]              wper_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [TW-1:0]            rdl_o,
  output logic [30:0]              rper_o
);

  logic [TW-1:0] dl_mem  [DEPTH];
  logic [30:0]   per_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dl_mem[waddr_i]  <= wdl_i;
      per_mem[waddr_i] <= wper_i;
    end
    rdl_o  <= dl_mem[raddr_i];
    rper_o <= per_mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/periodic_deadline_timer_queue.sv =====
// Top level of the periodic deadline timer queue.
`default_nettype none

// Timer queue with NUM_SLOTS task slots and a TIME_WIDTH-bit wrapping clock.
// One word is taken at a time; in_ready_o is low while it is being worked on.
// All arithmetic goes through one shared adder, and the deadlines and periods
// sit in a memory with one write port and one registered read port. A tick
// scans the memory in passes: one per reported slot plus a final pass that
// finds none, or 16 when it reports the maximum of 16. Each pass reads the
// memory one slot per cycle to find the earliest reached deadline. Results go
// out through an output register, so a waiting result stalls only the next one.

module periodic_deadline_timer_queue import pdtq_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [30:0] initial_delay_i,
  input  logic [30:0] period_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [3:0]  event_slot_o,
  output logic [31:0] time_now_o,
  output logic        last_o
);

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int ResW = $clog2(MAX_RESULTS + 1);

  fsm_e                  state_q, state_d;
  kind_e                 kind_q;
  logic [3:0]            slot_q;
  logic [30:0]           delay_q;
  logic [30:0]           period_q;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  slot_st_e              st_q [NUM_SLOTS];

  logic [CntW-1:0]       scan_cnt_q, scan_cnt_d;
  logic                  cmp_vld_q;
  logic [IdxW-1:0]       cmp_idx_q;
  logic                  best_vld_q, best_vld_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [TIME_WIDTH-1:0] best_age_q, best_age_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]       pend_idx_q, pend_idx_d;
  logic [ResW-1:0]       n_q, n_d;

  logic                  out_valid_q;
  logic [3:0]            event_res_q;
  logic [3:0]            event_slot_q;
  logic [31:0]           time_now_q;
  logic                  last_q;

  logic                  in_ready;
  logic                  out_free;
  logic [IdxW-1:0]       slot_idx;
  logic                  slot_ok;
  slot_st_e              cur_st;
  logic                  rd_issue;

  logic                  st_we;
  logic [IdxW-1:0]       st_widx;
  slot_st_e              st_wval;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [TIME_WIDTH-1:0] mem_wdl;
  logic [30:0]           mem_wper;
  logic [IdxW-1:0]       mem_raddr;
  logic [TIME_WIDTH-1:0] rd_dl;
  logic [30:0]           rd_per;

  alu_op_e               alu_op;
  logic [TIME_WIDTH-1:0] alu_a, alu_b, alu_y;

  logic                  emit;
  res_e                  emit_res;
  logic [3:0]            emit_slot;
  logic                  emit_last;

  pdtq_alu #(
    .W(TIME_WIDTH)
  ) u_pdtq_alu (
    .op_i(alu_op),
    .a_i (alu_a),
    .b_i (alu_b),
    .y_o (alu_y)
  );

  pdtq_mem #(
    .DEPTH(NUM_SLOTS),
    .TW   (TIME_WIDTH)
  ) u_pdtq_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdl_i  (mem_wdl),
    .wper_i (mem_wper),
    .raddr_i(mem_raddr),
    .rdl_o  (rd_dl),
    .rper_o (rd_per)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign slot_idx = IdxW'(slot_q);
  assign slot_ok  = {4'b0000, slot_q} < 8'(NUM_SLOTS);
  assign cur_st   = st_q[slot_idx];

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    scan_cnt_d = scan_cnt_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_age_d = best_age_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    n_d        = n_q;
    in_ready   = 1'b0;
    rd_issue   = 1'b0;
    st_we      = 1'b0;
    st_widx    = slot_idx;
    st_wval    = ST_IDLE;
    mem_we     = 1'b0;
    mem_waddr  = slot_idx;
    mem_wdl    = alu_y;
    mem_wper   = period_q;
    mem_raddr  = slot_idx;
    alu_op     = ALU_ADD;
    alu_a      = now_q;
    alu_b      = '0;
    emit       = 1'b0;
    emit_res   = RES_NO_EXPIRY;
    emit_slot  = slot_q;
    emit_last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = (kind_e'(kind_i) == KIND_TICK) ? S_TICK : S_CMD;
        end
      end

      S_TICK: begin
        alu_b      = TIME_WIDTH'(1);
        now_d      = alu_y;
        scan_cnt_d = '0;
        best_vld_d = 1'b0;
        pend_vld_d = 1'b0;
        n_d        = '0;
        state_d    = S_SCAN;
      end

      S_SCAN: begin
        // Reads are issued one slot per cycle; the age of each deadline is
        // compared in the cycle after, when its memory word returns.
        alu_op = ALU_SUB;
        alu_b  = rd_dl;
        if (scan_cnt_q < CntW'(NUM_SLOTS)) begin
          rd_issue   = 1'b1;
          mem_raddr  = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + CntW'(1);
        end
        if (cmp_vld_q && (st_q[cmp_idx_q] == ST_SCHEDULED) && !alu_y[TIME_WIDTH-1] &&
            (!best_vld_q || (alu_y > best_age_q))) begin
          best_vld_d = 1'b1;
          best_idx_d = cmp_idx_q;
          best_age_d = alu_y;
        end
        if (cmp_vld_q && (cmp_idx_q == IdxW'(NUM_SLOTS - 1))) begin
          state_d = S_PASS_END;
        end
      end

      S_PASS_END: begin
        // The previous expiry is held back until we know whether another
        // one follows, so that its last flag is right.
        if (best_vld_q) begin
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              emit      = 1'b1;
              emit_res  = RES_EXPIRED;
              emit_slot = 4'(pend_idx_q);
              emit_last = 1'b0;
            end
            st_we      = 1'b1;
            st_widx    = best_idx_q;
            st_wval    = ST_RUNNING;
            pend_vld_d = 1'b1;
            pend_idx_d = best_idx_q;
            n_d        = n_q + ResW'(1);
            if (n_q + ResW'(1) == ResW'(MAX_RESULTS)) begin
              state_d = S_FINAL;
            end else begin
              scan_cnt_d = '0;
              best_vld_d = 1'b0;
              state_d    = S_SCAN;
            end
          end
        end else begin
          state_d = S_FINAL;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_vld_q) begin
            emit_res  = RES_EXPIRED;
            emit_slot = 4'(pend_idx_q);
          end else begin
            emit_res  = RES_NO_EXPIRY;
            emit_slot = 4'd0;
          end
          state_d = S_IDLE;
        end
      end

      S_CMD: begin
        if (out_free) begin
          state_d = S_IDLE;
          unique case (kind_q)
            KIND_START: begin
              emit = 1'b1;
              if (slot_ok && (cur_st == ST_IDLE)) begin
                alu_b    = TIME_WIDTH'(delay_q);
                mem_we   = 1'b1;
                st_we    = 1'b1;
                st_wval  = ST_SCHEDULED;
                emit_res = RES_STARTED;
              end else begin
                emit_res = RES_START_IGN;
              end
            end
            KIND_CANCEL: begin
              emit = 1'b1;
              if (slot_ok && ((cur_st == ST_SCHEDULED) || (cur_st == ST_RUNNING))) begin
                st_we    = 1'b1;
                st_wval  = ST_CANCELLED;
                emit_res = RES_CANCELLED;
              end else begin
                emit_res = RES_CANCEL_IGN;
              end
            end
            KIND_DONE: begin
              if (slot_ok && (cur_st == ST_CANCELLED)) begin
                emit     = 1'b1;
                emit_res = RES_CANCEL_ACK;
              end else if (slot_ok && (cur_st == ST_RUNNING)) begin
                // The memory read of this slot is in flight this cycle.
                state_d = S_DONE_UPD;
              end
            end
            KIND_TICK: begin
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_DONE_UPD: begin
        alu_a = rd_dl;
        alu_b = TIME_WIDTH'(rd_per);
        if (out_free) begin
          emit  = 1'b1;
          st_we = 1'b1;
          if (rd_per != 31'd0) begin
            mem_we   = 1'b1;
            mem_wper = rd_per;
            st_wval  = ST_SCHEDULED;
            emit_res = RES_RESCHEDULED;
          end else begin
            st_wval  = ST_COMPLETED;
            emit_res = RES_COMPLETED;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      scan_cnt_q  <= '0;
      cmp_vld_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_q[i] <= ST_IDLE;
      end
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= rd_issue;
      best_vld_q <= best_vld_d;
      pend_vld_q <= pend_vld_d;
      n_q        <= n_d;
      if (st_we) begin
        st_q[st_widx] <= st_wval;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      kind_q   <= kind_e'(kind_i);
      slot_q   <= slot_i;
      delay_q  <= initial_delay_i;
      period_q <= period_i;
    end
    cmp_idx_q  <= mem_raddr;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    pend_idx_q <= pend_idx_d;
    if (emit) begin
      event_res_q  <= emit_res;
      event_slot_q <= emit_slot;
      time_now_q   <= 32'(now_q);
      last_q       <= emit_last;
    end
  end

  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;
  assign event_res_o  = event_res_q;
  assign event_slot_o = event_slot_q;
  assign time_now_o   = time_now_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== hdl/pdtq_checker.sv =====
// Port-level checks of the timer queue, bound to the top level.
`default_nettype none

module pdtq_checker import pdtq_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  event_res_o,
  input wire logic [3:0]  event_slot_o,
  input wire logic [31:0] time_now_o,
  input wire logic        last_o
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({event_res_o, event_slot_o, time_now_o, last_o}))
    else $error("stalled result word changed");

  // One word at a time: the block is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Only expiries can be followed by further results of the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != RES_EXPIRED) |-> last_o)
    else $error("non-expiry result without last");

  // A tick without expiry reports slot zero and is alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == RES_NO_EXPIRY) |-> last_o && (event_slot_o == 4'd0))
    else $error("bad no-expiry result");

endmodule

bind periodic_deadline_timer_queue pdtq_checker u_pdtq_checker (.*);

`default_nettype wire
